[rtl/cde_pkg.sv]
// Shared types and byte codes for the charset designation encoder.
`default_nettype none
package cde_pkg;

    localparam int unsigned MAX_BYTES = 8;

    localparam logic [7:0] ESC_BYTE      = 8'h1B;
    localparam logic [7:0] LS0_BYTE      = 8'h0F;
    localparam logic [7:0] LS1_BYTE      = 8'h0E;
    localparam logic [7:0] LS2_BYTE      = 8'h6E;
    localparam logic [7:0] LS3_BYTE      = 8'h6F;
    localparam logic [7:0] LS1R_BYTE     = 8'h7E;
    localparam logic [7:0] LS2R_BYTE     = 8'h7D;
    localparam logic [7:0] LS3R_BYTE     = 8'h7C;
    localparam logic [7:0] DESIG_BASE    = 8'h28;
    localparam logic [7:0] DESIG_MULTI   = 8'h24;
    localparam logic [7:0] GR_BIT        = 8'h80;

    localparam logic [2:0] CFG_INIT_G0   = 3'd0;
    localparam logic [2:0] CFG_INIT_G1   = 3'd1;
    localparam logic [2:0] CFG_INIT_G2   = 3'd2;
    localparam logic [2:0] CFG_INIT_G3   = 3'd3;

    localparam logic [7:0] RST_G0_FINAL  = 8'd66;
    localparam logic [7:0] RST_G1_FINAL  = 8'd74;
    localparam logic [7:0] RST_G2_FINAL  = 8'd48;
    localparam logic [7:0] RST_G3_FINAL  = 8'd49;

    localparam logic [1:0] START_GL      = 2'd0;
    localparam logic [1:0] START_GR      = 2'd2;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] seq;
        logic [3:0]                len;
        logic                      status;
    } t_entry;

endpackage
`default_nettype wire

[rtl/charset_designation_encoder_top.sv]
// Top level of the charset designation encoder.
//
//  channel  direction  handshake               word
//  cfg      in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//  char     in         i_valid/o_stall         new_string .. free_space
//  byte     out        o_valid/i_stall         out_byte, last, status
//
// Each character emits 1 to 8 bytes (usually 1 or 2); the output register moves
// one byte a cycle while i_stall is low.
// The front end builds the whole sequence in the accept cycle; a two-entry queue
// lets it take the next character while bytes are still going out.
// Synchronous active-low reset restores slots, invocations and init registers.
// o_stall rises only when the queue is full; i_stall holds the output word.
`default_nettype none
module charset_designation_encoder_top
    import cde_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_new_string,
    input  wire logic [7:0] i_charset_final,
    input  wire logic       i_two_byte,
    input  wire logic [6:0] i_row_code,
    input  wire logic [6:0] i_column_code,
    input  wire logic [7:0] i_free_space,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic            o_status
);

    logic   push, pop, q_valid, q_full;
    t_entry f_entry, q_entry;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;

    cde_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .i_new_string    (i_new_string),
        .i_charset_final (i_charset_final),
        .i_two_byte      (i_two_byte),
        .i_row_code      (i_row_code),
        .i_column_code   (i_column_code),
        .i_free_space    (i_free_space),
        .i_full          (q_full),
        .o_push          (push),
        .o_entry         (f_entry)
    );

    cde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_entry (q_entry)
    );

    cde_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .o_status   (o_status)
    );

endmodule
`default_nettype wire

[rtl/cde_front.sv]
// Front end: config registers, designation state and byte sequence build per character.
`default_nettype none
module cde_front
    import cde_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_valid,
    input  wire logic       i_new_string,
    input  wire logic [7:0] i_charset_final,
    input  wire logic       i_two_byte,
    input  wire logic [6:0] i_row_code,
    input  wire logic [6:0] i_column_code,
    input  wire logic [7:0] i_free_space,
    input  wire logic       i_full,
    output logic            o_push,
    output t_entry          o_entry
);

    logic [3:0][7:0] r_init_final;
    logic [3:0][7:0] r_slot_final, n_slot_final;
    logic [1:0]      r_gl, n_gl;
    logic [1:0]      r_gr, n_gr;
    logic            r_gl_was_last, n_gl_was_last;
    logic [3:0][1:0] r_age, n_age;

    logic [3:0][7:0] e_final;
    logic [1:0]      e_gl, e_gr;
    logic            e_glwl;
    logic [3:0][1:0] e_age;
    logic [3:0][7:0] c_final;
    logic [1:0]      c_gl, c_gr;
    logic [3:0][1:0] c_age;
    logic            hit_gl, hit_gr, need, designate, no_room;
    logic [1:0]      idx, s;
    logic [MAX_BYTES-1:0][7:0] seq;
    logic [3:0]      len, total;
    logic [7:0]      mask;

    always_comb begin
        if (i_new_string) begin
            e_final = r_init_final;
            e_gl    = START_GL;
            e_gr    = START_GR;
            e_glwl  = 1'b0;
            e_age   = {2'd3, 2'd2, 2'd1, 2'd0};
        end else begin
            e_final = r_slot_final;
            e_gl    = r_gl;
            e_gr    = r_gr;
            e_glwl  = r_gl_was_last;
            e_age   = r_age;
        end

        hit_gl    = (i_charset_final == e_final[e_gl]);
        hit_gr    = (i_charset_final == e_final[e_gr]);
        need      = !hit_gl && !hit_gr;
        designate = need && (i_charset_final != e_final[0]) && (i_charset_final != e_final[1])
                    && (i_charset_final != e_final[2]) && (i_charset_final != e_final[3]);
        idx       = e_age[3];

        c_final = e_final;
        c_gl    = e_gl;
        c_gr    = e_gr;
        c_age   = e_age;
        seq     = '0;
        len     = 4'd0;

        if (designate) begin
            c_final[idx] = i_charset_final;
            c_age        = {e_age[2:0], idx};
            seq[len[2:0]] = ESC_BYTE;
            len = len + 4'd1;
            if (!i_two_byte) begin
                seq[len[2:0]] = DESIG_BASE + {6'd0, idx};
                len = len + 4'd1;
            end else begin
                seq[len[2:0]] = DESIG_MULTI;
                len = len + 4'd1;
                if (idx != 2'd0) begin
                    seq[len[2:0]] = DESIG_BASE + {6'd0, idx};
                    len = len + 4'd1;
                end
            end
            seq[len[2:0]] = i_charset_final;
            len = len + 4'd1;
        end

        priority if (i_charset_final == c_final[0]) s = 2'd0;
        else if (i_charset_final == c_final[1])     s = 2'd1;
        else if (i_charset_final == c_final[2])     s = 2'd2;
        else                                        s = 2'd3;

        if (need) begin
            if (s == 2'd0) begin
                c_gl = 2'd0;
                seq[len[2:0]] = LS0_BYTE;
                len = len + 4'd1;
            end else if (e_glwl) begin
                c_gr = s;
                seq[len[2:0]] = ESC_BYTE;
                len = len + 4'd1;
                seq[len[2:0]] = (s == 2'd1) ? LS1R_BYTE : (s == 2'd2) ? LS2R_BYTE : LS3R_BYTE;
                len = len + 4'd1;
            end else begin
                c_gl = s;
                if (s == 2'd1) begin
                    seq[len[2:0]] = LS1_BYTE;
                    len = len + 4'd1;
                end else begin
                    seq[len[2:0]] = ESC_BYTE;
                    len = len + 4'd1;
                    seq[len[2:0]] = (s == 2'd2) ? LS2_BYTE : LS3_BYTE;
                    len = len + 4'd1;
                end
            end
        end

        total   = len + (i_two_byte ? 4'd2 : 4'd1);
        no_room = ({4'd0, total} > i_free_space);
        mask    = (c_final[c_gr] == i_charset_final) ? GR_BIT : 8'h00;

        if (i_two_byte) begin
            seq[len[2:0]] = {1'b0, i_row_code} | mask;
            len = len + 4'd1;
        end
        seq[len[2:0]] = {1'b0, i_column_code} | mask;
        len = len + 4'd1;

        if (no_room) begin
            o_entry.seq    = '0;
            o_entry.len    = 4'd1;
            o_entry.status = 1'b1;
            n_slot_final   = e_final;
            n_gl           = e_gl;
            n_gr           = e_gr;
            n_gl_was_last  = e_glwl;
            n_age          = e_age;
        end else begin
            o_entry.seq    = seq;
            o_entry.len    = len;
            o_entry.status = 1'b0;
            n_slot_final   = c_final;
            n_gl           = c_gl;
            n_gr           = c_gr;
            n_gl_was_last  = (c_final[c_gl] == i_charset_final);
            n_age          = c_age;
        end
    end

    assign o_push = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_final  <= {RST_G3_FINAL, RST_G2_FINAL, RST_G1_FINAL, RST_G0_FINAL};
            r_slot_final  <= {RST_G3_FINAL, RST_G2_FINAL, RST_G1_FINAL, RST_G0_FINAL};
            r_gl          <= START_GL;
            r_gr          <= START_GR;
            r_gl_was_last <= 1'b0;
            r_age         <= {2'd3, 2'd2, 2'd1, 2'd0};
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_INIT_G0: r_init_final[0] <= i_cfg_data;
                    CFG_INIT_G1: r_init_final[1] <= i_cfg_data;
                    CFG_INIT_G2: r_init_final[2] <= i_cfg_data;
                    CFG_INIT_G3: r_init_final[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_push) begin
                r_slot_final  <= n_slot_final;
                r_gl          <= n_gl;
                r_gr          <= n_gr;
                r_gl_was_last <= n_gl_was_last;
                r_age         <= n_age;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/cde_queue.sv]
// Two-entry queue between front end and byte serializer.
`default_nettype none
module cde_queue
    import cde_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_entry    i_entry,
    input  wire logic i_pop,
    output logic      o_valid,
    output logic      o_full,
    output t_entry    o_entry
);

    t_entry     r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

[rtl/cde_back.sv]
// Back end: walks a queued sequence one byte a cycle into the output register while not stalled.
`default_nettype none
module cde_back
    import cde_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  t_entry          i_q_entry,
    output logic            o_pop,
    input  wire logic       i_stall,
    output logic            o_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic            o_status
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last, r_status;
    logic       load, is_last;

    assign load    = !r_valid || !i_stall;
    assign is_last = ({1'b0, r_idx} + 4'd1) == i_q_entry.len;
    assign o_pop   = load && i_q_valid && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= is_last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_byte   <= i_q_entry.seq[r_idx];
            r_last   <= is_last;
            r_status <= i_q_entry.status;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;
    assign o_status   = r_status;

endmodule
`default_nettype wire

[rtl/cde_checker.sv]
// Port-level checker for the charset designation encoder, bound to the top level.
`default_nettype none
module cde_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last,
    input wire logic       o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_byte) && $stable(o_last)
                                  && $stable(o_status)))
        else $error("output word changed while stalled");

    a_noroom_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> o_last)
        else $error("no_room word is not last");

    a_noroom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_out_byte == 8'h00))
        else $error("no_room word carries a byte");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind charset_designation_encoder_top cde_checker u_cde_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_byte (o_out_byte),
    .o_last     (o_last),
    .o_status   (o_status)
);
`default_nettype wire
